// ----- hdl/nmea_depth_temp_parser_core_assert.svh -----
// Assertion macros shared by the parser and the conversion stage.
`ifndef NMEA_DEPTH_TEMP_PARSER_CORE_ASSERT_SVH
`define NMEA_DEPTH_TEMP_PARSER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge out of reset
`define NDTP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ndtp: same-cycle check failed");
// next-cycle implication
`define NDTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ndtp: next-cycle check failed");
`else
`define NDTP_ASSERT_IMP(label, ante, cons)
`define NDTP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/ndtp_pkg.sv -----
// Package: types, character codes and small helper functions of the NMEA depth/temp parser.
`timescale 1ns / 1ps

package ndtp_pkg;

    // default configuration
    localparam int MAX_BODY_DEF    = 128;
    localparam int FRAC_DIGITS_DEF = 3;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_W     = 8'h57;

    // reading kinds on the output
    localparam logic READ_DEPTH = 1'b0;
    localparam logic READ_TEMP  = 1'b1;

    // Fahrenheit conversion: 32.000 degrees in thousandths, and floor(x/9) for
    // any 32-bit x is (x * NINTH_MAGIC) >> NINTH_SHIFT
    localparam logic signed [32:0] F_OFFSET    = 33'sd32000;
    localparam logic [29:0]        NINTH_MAGIC = 30'd954437177;
    localparam int                 NINTH_SHIFT = 33;

    localparam logic [31:0]        MAG_MAX = 32'hFFFF_FFFF;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    // header match position
    typedef enum logic [2:0] {
        HDR_IDLE,
        HDR_DOLLAR,
        HDR_I,
        HDR_N,
        HDR_TAIL1,
        HDR_TAIL2,
        HDR_BODY
    } hdr_t;

    typedef enum logic [1:0] {
        SENT_NONE,
        SENT_DEPTH,
        SENT_TEMP
    } sent_t;

    // body scan phase; 1..3 first number, 4..6 second number
    typedef enum logic [2:0] {
        PH_COMMA,
        PH_LEAD1,
        PH_INT1,
        PH_FRAC1,
        PH_LEAD2,
        PH_INT2,
        PH_FRAC2,
        PH_DONE
    } phase_t;

    // finished sentence handed from the parser to the conversion stage
    typedef struct packed {
        logic               kind;
        logic signed [31:0] first;
        logic signed [31:0] second;
        logic               celsius;
        logic               log_ready;
    } token_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF)
            || (c == CH_CR) || (c == CH_LF);
    endfunction

    // sign plus magnitude to a saturated signed word
    function automatic logic signed [31:0] number_value(input logic neg,
                                                        input logic [31:0] mag);
        logic signed [31:0] v;
        if (neg)
        begin
            v = mag[31] ? INT_MIN : -$signed(mag);
        end
        else
        begin
            v = mag[31] ? INT_MAX : $signed(mag);
        end
        return v;
    endfunction

    // weight of a fraction digit in thousandths
    function automatic logic [9:0] frac_weight(input logic [1:0] cnt, input logic [3:0] d);
        logic [9:0] w;
        unique case (cnt)
            2'd0:    w = 10'(d) * 10'd100;
            2'd1:    w = 10'(d) * 10'd10;
            default: w = 10'(d);
        endcase
        return w;
    endfunction

    // floor(5 * r / 9) for a remainder of a division by nine
    function automatic logic [2:0] five_ninths(input logic [3:0] r);
        logic [2:0] q;
        unique case (r)
            4'd0, 4'd1: q = 3'd0;
            4'd2, 4'd3: q = 3'd1;
            4'd4, 4'd5: q = 3'd2;
            4'd6, 4'd7: q = 3'd3;
            4'd8:       q = 3'd4;
            default:    q = 3'd0;
        endcase
        return q;
    endfunction

endpackage

// ----- hdl/ndtp_if.sv -----
// Stream interfaces: received characters in, readings out.
`timescale 1ns / 1ps

interface ndtp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ndtp_reading_if;
    logic               valid;
    logic               ready;
    logic               reading_kind;
    logic signed [31:0] reading_value;
    logic               log_ready;

    modport source (output valid, output reading_kind, output reading_value,
                    output log_ready, input ready);
    modport sink   (input valid, input reading_kind, input reading_value,
                    input log_ready, output ready);
endinterface

// ----- hdl/ndtp_parser.sv -----
// Character parser: header match, number scan and sentence token register.
`timescale 1ns / 1ps
`include "nmea_depth_temp_parser_core_assert.svh"

module ndtp_parser #(
    parameter int MAX_BODY        = ndtp_pkg::MAX_BODY_DEF,
    parameter int FRACTION_DIGITS = ndtp_pkg::FRAC_DIGITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    ndtp_byte_if.sink         serial,
    output logic              tok_valid,
    input  logic              tok_ready,
    output ndtp_pkg::token_t  tok
);

    localparam int BODY_W = $clog2(MAX_BODY + 1);
    localparam int CNT_W  = $clog2(FRACTION_DIGITS + 1);
    localparam logic [BODY_W-1:0] BODY_LIMIT = BODY_W'(MAX_BODY);
    localparam logic [CNT_W-1:0]  CNT_LIMIT  = CNT_W'(FRACTION_DIGITS);

    // ",C*" tracker codes
    localparam logic [1:0] CM_IDLE  = 2'd0;
    localparam logic [1:0] CM_COMMA = 2'd1;
    localparam logic [1:0] CM_C     = 2'd2;

    ndtp_pkg::hdr_t       hdr_reg, hdr_next;
    ndtp_pkg::sent_t      sent_reg, sent_next, sent_pick;
    ndtp_pkg::phase_t     phase_reg, phase_next;
    logic [BODY_W-1:0]    body_len_reg, body_len_next;
    logic                 neg_reg, neg_next;
    logic [31:0]          mag_reg, mag_next;
    logic [CNT_W-1:0]     frac_cnt_reg, frac_cnt_next;
    logic                 digit_seen_reg, digit_seen_next;
    logic signed [31:0]   first_reg, first_next;
    logic                 failed_reg, failed_next;
    logic [1:0]           cmatch_reg, cmatch_next;
    logic                 cfound_reg, cfound_next;
    logic                 temp_seen_reg, temp_seen_next;
    logic                 tok_valid_reg, tok_valid_next;
    ndtp_pkg::token_t     tok_reg, tok_new;

    logic                 accept;
    logic                 tok_fire;
    logic [7:0]           c;
    logic [7:0]           pc;
    logic                 eol;
    logic                 is_digit;
    logic [3:0]           d;
    logic [35:0]          int_sum;
    logic [31:0]          int_mag;
    logic [32:0]          frac_sum;
    logic [31:0]          frac_mag;
    logic signed [31:0]   num_val;
    logic                 hdr_ok;
    logic                 fail_now;
    logic                 second;
    logic                 end_num;
    logic                 clear_num;

    assign accept       = serial.valid && serial.ready;
    assign serial.ready = !tok_valid_reg || tok_ready;
    assign tok_valid    = tok_valid_reg;
    assign tok          = tok_reg;

    // character classes and digit arithmetic
    always_comb
    begin
        c        = serial.rx_byte;
        eol      = (c == ndtp_pkg::CH_CR) || (c == ndtp_pkg::CH_LF);
        pc       = eol ? ndtp_pkg::CH_NUL : c;
        is_digit = (pc >= ndtp_pkg::CH_ZERO) && (pc <= ndtp_pkg::CH_NINE);
        d        = pc[3:0];
        int_sum  = (36'(mag_reg) << 3) + (36'(mag_reg) << 1) + 36'(d) * 36'd1000;
        int_mag  = (|int_sum[35:32]) ? ndtp_pkg::MAG_MAX : int_sum[31:0];
        frac_sum = 33'(mag_reg) + 33'(ndtp_pkg::frac_weight(2'(frac_cnt_reg), d));
        frac_mag = frac_sum[32] ? ndtp_pkg::MAG_MAX : frac_sum[31:0];
        num_val  = ndtp_pkg::number_value(neg_reg, mag_reg);
    end

    // next state for one accepted word
    always_comb
    begin
        hdr_next        = hdr_reg;
        sent_next       = sent_reg;
        sent_pick       = sent_reg;
        phase_next      = phase_reg;
        body_len_next   = body_len_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        frac_cnt_next   = frac_cnt_reg;
        digit_seen_next = digit_seen_reg;
        first_next      = first_reg;
        failed_next     = failed_reg;
        cmatch_next     = cmatch_reg;
        cfound_next     = cfound_reg;
        temp_seen_next  = temp_seen_reg;
        tok_fire        = 1'b0;
        tok_new         = '0;
        hdr_ok          = 1'b0;
        fail_now        = failed_reg;
        second          = (phase_reg == ndtp_pkg::PH_LEAD2) || (phase_reg == ndtp_pkg::PH_INT2)
                       || (phase_reg == ndtp_pkg::PH_FRAC2);
        end_num         = 1'b0;
        clear_num       = 1'b0;

        if (accept)
        begin
            if (hdr_reg != ndtp_pkg::HDR_BODY)
            begin
                // header match; CR/LF drops any partial match
                if (eol)
                begin
                    hdr_next  = ndtp_pkg::HDR_IDLE;
                    sent_next = ndtp_pkg::SENT_NONE;
                end
                else
                begin
                    unique case (hdr_reg)
                        ndtp_pkg::HDR_IDLE:   hdr_ok = (c == ndtp_pkg::CH_DOLLAR);
                        ndtp_pkg::HDR_DOLLAR: hdr_ok = (c == ndtp_pkg::CH_I);
                        ndtp_pkg::HDR_I:      hdr_ok = (c == ndtp_pkg::CH_N);
                        ndtp_pkg::HDR_N:
                        begin
                            if (c == ndtp_pkg::CH_D)
                            begin
                                hdr_ok    = 1'b1;
                                sent_pick = ndtp_pkg::SENT_DEPTH;
                            end
                            else if (c == ndtp_pkg::CH_M)
                            begin
                                hdr_ok    = 1'b1;
                                sent_pick = ndtp_pkg::SENT_TEMP;
                            end
                        end
                        ndtp_pkg::HDR_TAIL1:
                            hdr_ok = (c == ((sent_reg == ndtp_pkg::SENT_DEPTH)
                                            ? ndtp_pkg::CH_P : ndtp_pkg::CH_T));
                        ndtp_pkg::HDR_TAIL2:
                            hdr_ok = (c == ((sent_reg == ndtp_pkg::SENT_DEPTH)
                                            ? ndtp_pkg::CH_T : ndtp_pkg::CH_W));
                        default: hdr_ok = 1'b0;
                    endcase

                    if (hdr_ok)
                    begin
                        sent_next = sent_pick;
                        if (hdr_reg == ndtp_pkg::HDR_TAIL2)
                        begin
                            // header complete: start a fresh body
                            hdr_next      = ndtp_pkg::HDR_BODY;
                            body_len_next = '0;
                            phase_next    = ndtp_pkg::PH_COMMA;
                            failed_next   = 1'b0;
                            cmatch_next   = CM_IDLE;
                            cfound_next   = 1'b0;
                            first_next    = '0;
                            clear_num     = 1'b1;
                        end
                        else
                        begin
                            hdr_next = ndtp_pkg::hdr_t'(hdr_reg + 3'd1);
                        end
                    end
                    else
                    begin
                        sent_next = ndtp_pkg::SENT_NONE;
                        hdr_next  = (c == ndtp_pkg::CH_DOLLAR) ? ndtp_pkg::HDR_DOLLAR
                                                               : ndtp_pkg::HDR_IDLE;
                    end
                end
            end
            else
            begin
                // body length limit and ",C*" tracking
                if (!eol)
                begin
                    if (body_len_reg >= BODY_LIMIT)
                        fail_now = 1'b1;
                    else
                        body_len_next = BODY_W'(body_len_reg + 1'b1);

                    if ((cmatch_reg == CM_COMMA) && (c == ndtp_pkg::CH_C))
                        cmatch_next = CM_C;
                    else if ((cmatch_reg == CM_C) && (c == ndtp_pkg::CH_STAR))
                    begin
                        cfound_next = 1'b1;
                        cmatch_next = CM_IDLE;
                    end
                    else
                        cmatch_next = (c == ndtp_pkg::CH_COMMA) ? CM_COMMA : CM_IDLE;
                end
                failed_next = fail_now;

                // number scan; end of line scans as NUL
                if (!fail_now && (phase_reg != ndtp_pkg::PH_DONE))
                begin
                    unique case (phase_reg)
                        ndtp_pkg::PH_COMMA:
                        begin
                            if (pc == ndtp_pkg::CH_COMMA)
                            begin
                                phase_next = ndtp_pkg::PH_LEAD1;
                                clear_num  = 1'b1;
                            end
                            else
                                failed_next = 1'b1;
                        end
                        ndtp_pkg::PH_LEAD1, ndtp_pkg::PH_LEAD2:
                        begin
                            if (ndtp_pkg::is_blank(pc))
                                phase_next = phase_reg;
                            else if ((pc == ndtp_pkg::CH_PLUS) || (pc == ndtp_pkg::CH_MINUS))
                            begin
                                neg_next   = (pc == ndtp_pkg::CH_MINUS);
                                phase_next = second ? ndtp_pkg::PH_INT2 : ndtp_pkg::PH_INT1;
                            end
                            else if (is_digit)
                            begin
                                mag_next        = int_mag;
                                digit_seen_next = 1'b1;
                                phase_next = second ? ndtp_pkg::PH_INT2 : ndtp_pkg::PH_INT1;
                            end
                            else if (pc == ndtp_pkg::CH_POINT)
                                phase_next = second ? ndtp_pkg::PH_FRAC2 : ndtp_pkg::PH_FRAC1;
                            else
                                failed_next = 1'b1;
                        end
                        ndtp_pkg::PH_INT1, ndtp_pkg::PH_INT2:
                        begin
                            if (is_digit)
                            begin
                                mag_next        = int_mag;
                                digit_seen_next = 1'b1;
                            end
                            else if (pc == ndtp_pkg::CH_POINT)
                                phase_next = second ? ndtp_pkg::PH_FRAC2 : ndtp_pkg::PH_FRAC1;
                            else
                                end_num = 1'b1;
                        end
                        ndtp_pkg::PH_FRAC1, ndtp_pkg::PH_FRAC2:
                        begin
                            if (is_digit)
                            begin
                                // digits past the kept precision are dropped
                                if (frac_cnt_reg < CNT_LIMIT)
                                begin
                                    mag_next      = frac_mag;
                                    frac_cnt_next = CNT_W'(frac_cnt_reg + 1'b1);
                                end
                                digit_seen_next = 1'b1;
                            end
                            else
                                end_num = 1'b1;
                        end
                        default: phase_next = phase_reg;
                    endcase

                    // a number has ended
                    if (end_num)
                    begin
                        if (!digit_seen_reg)
                            failed_next = 1'b1;
                        else if (!second)
                        begin
                            first_next = num_val;
                            if (sent_reg == ndtp_pkg::SENT_DEPTH)
                            begin
                                if (pc == ndtp_pkg::CH_COMMA)
                                begin
                                    phase_next = ndtp_pkg::PH_LEAD2;
                                    clear_num  = 1'b1;
                                end
                                else
                                    failed_next = 1'b1;
                            end
                            else
                                phase_next = ndtp_pkg::PH_DONE;
                        end
                        else
                            phase_next = ndtp_pkg::PH_DONE;
                    end
                end

                if (clear_num)
                begin
                    neg_next        = 1'b0;
                    mag_next        = '0;
                    frac_cnt_next   = '0;
                    digit_seen_next = 1'b0;
                end

                // end of sentence: build the token and go back to header search
                if (eol)
                begin
                    if (!failed_next && (phase_next == ndtp_pkg::PH_DONE))
                    begin
                        if (sent_reg == ndtp_pkg::SENT_DEPTH)
                        begin
                            if (!neg_reg || (mag_reg == '0))
                            begin
                                tok_fire          = 1'b1;
                                tok_new.kind      = ndtp_pkg::READ_DEPTH;
                                tok_new.first     = first_next;
                                tok_new.second    = num_val;
                                tok_new.celsius   = 1'b0;
                                tok_new.log_ready = temp_seen_reg;
                            end
                        end
                        else if (sent_reg == ndtp_pkg::SENT_TEMP)
                        begin
                            tok_fire          = 1'b1;
                            tok_new.kind      = ndtp_pkg::READ_TEMP;
                            tok_new.first     = first_next;
                            tok_new.second    = '0;
                            tok_new.celsius   = cfound_reg;
                            tok_new.log_ready = 1'b0;
                            temp_seen_next    = 1'b1;
                        end
                    end
                    hdr_next    = ndtp_pkg::HDR_IDLE;
                    sent_next   = ndtp_pkg::SENT_NONE;
                    phase_next  = ndtp_pkg::PH_COMMA;
                    failed_next = 1'b0;
                end
            end
        end

        // token register handshake
        if (tok_fire)
            tok_valid_next = 1'b1;
        else if (tok_valid_reg && tok_ready)
            tok_valid_next = 1'b0;
        else
            tok_valid_next = tok_valid_reg;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg        <= ndtp_pkg::HDR_IDLE;
            sent_reg       <= ndtp_pkg::SENT_NONE;
            phase_reg      <= ndtp_pkg::PH_COMMA;
            body_len_reg   <= '0;
            neg_reg        <= 1'b0;
            mag_reg        <= '0;
            frac_cnt_reg   <= '0;
            digit_seen_reg <= 1'b0;
            first_reg      <= '0;
            failed_reg     <= 1'b0;
            cmatch_reg     <= CM_IDLE;
            cfound_reg     <= 1'b0;
            temp_seen_reg  <= 1'b0;
            tok_valid_reg  <= 1'b0;
        end
        else
        begin
            hdr_reg        <= hdr_next;
            sent_reg       <= sent_next;
            phase_reg      <= phase_next;
            body_len_reg   <= body_len_next;
            neg_reg        <= neg_next;
            mag_reg        <= mag_next;
            frac_cnt_reg   <= frac_cnt_next;
            digit_seen_reg <= digit_seen_next;
            first_reg      <= first_next;
            failed_reg     <= failed_next;
            cmatch_reg     <= cmatch_next;
            cfound_reg     <= cfound_next;
            temp_seen_reg  <= temp_seen_next;
            tok_valid_reg  <= tok_valid_next;
        end
    end

    // token payload
    always_ff @(posedge clk)
    begin
        if (tok_fire)
            tok_reg <= tok_new;
    end

    // a body is only entered after a full header names its type
    `NDTP_ASSERT_IMP(a_body_has_type, hdr_reg == ndtp_pkg::HDR_BODY, sent_reg != ndtp_pkg::SENT_NONE)
    // the body counter never passes the limit
    `NDTP_ASSERT_IMP(a_body_len_bound, hdr_reg == ndtp_pkg::HDR_BODY, body_len_reg <= BODY_LIMIT)
    // every temperature token marks later depth readings as loggable
    `NDTP_ASSERT_NEXT(a_temp_marks_log, tok_fire && (tok_new.kind == ndtp_pkg::READ_TEMP), temp_seen_reg)

endmodule

// ----- hdl/ndtp_convert.sv -----
// Conversion pipeline: depth sum, Fahrenheit to Celsius, and the output register.
`timescale 1ns / 1ps
`include "nmea_depth_temp_parser_core_assert.svh"

module ndtp_convert (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    output logic              tok_ready,
    input  ndtp_pkg::token_t  tok,
    ndtp_reading_if.source    readings
);

    logic               a_valid_reg;
    logic               a_kind_reg;
    logic               a_log_reg;
    logic               a_direct_reg;
    logic signed [31:0] a_value_reg;
    logic               a_neg_reg;
    logic [31:0]        a_mag_reg;
    logic [28:0]        a_quot_reg;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic signed [31:0] out_value_reg;
    logic               out_log_reg;

    logic               out_ready;
    logic               a_load;
    logic               a_move;
    logic [32:0]        depth_sum;
    logic signed [31:0] depth_sat;
    logic [32:0]        f_diff;
    logic [32:0]        f_neg_diff;
    logic               f_neg;
    logic [31:0]        f_mag;
    logic [61:0]        f_prod;
    logic               direct;
    logic signed [31:0] direct_value;
    logic [31:0]        nine_q;
    logic [3:0]         rem;
    logic [31:0]        scaled;
    logic signed [31:0] conv_value;

    assign out_ready = !out_valid_reg || readings.ready;
    assign tok_ready = !a_valid_reg || out_ready;
    assign a_load    = tok_valid && tok_ready;
    assign a_move    = a_valid_reg && out_ready;

    // stage A: depth sum with saturation, Fahrenheit magnitude times 1/9
    always_comb
    begin
        depth_sum = {tok.first[31], tok.first} + {tok.second[31], tok.second};
        if (depth_sum[32] != depth_sum[31])
            depth_sat = depth_sum[32] ? ndtp_pkg::INT_MIN : ndtp_pkg::INT_MAX;
        else
            depth_sat = $signed(depth_sum[31:0]);

        f_diff     = {tok.first[31], tok.first} - ndtp_pkg::F_OFFSET;
        f_neg_diff = 33'(-$signed(f_diff));
        f_neg      = f_diff[32];
        f_mag      = f_neg ? f_neg_diff[31:0] : f_diff[31:0];
        f_prod     = 62'(f_mag) * 62'(ndtp_pkg::NINTH_MAGIC);

        direct       = (tok.kind == ndtp_pkg::READ_DEPTH) || tok.celsius;
        direct_value = (tok.kind == ndtp_pkg::READ_DEPTH) ? depth_sat : tok.first;
    end

    // stage B: 5*m/9 = 5*floor(m/9) + floor(5*rem/9), sign restored
    always_comb
    begin
        nine_q     = {a_quot_reg, 3'b000} + 32'(a_quot_reg);
        rem        = a_mag_reg[3:0] - nine_q[3:0];
        scaled     = 32'({a_quot_reg, 2'b00}) + 32'(a_quot_reg)
                   + 32'(ndtp_pkg::five_ninths(rem));
        conv_value = a_neg_reg ? -$signed(scaled) : $signed(scaled);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tok_ready)
                a_valid_reg <= tok_valid;
            if (out_ready)
                out_valid_reg <= a_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_kind_reg   <= tok.kind;
            a_log_reg    <= tok.log_ready;
            a_direct_reg <= direct;
            a_value_reg  <= direct_value;
            a_neg_reg    <= f_neg;
            a_mag_reg    <= f_mag;
            a_quot_reg   <= f_prod[61:ndtp_pkg::NINTH_SHIFT];
        end
        if (a_move)
        begin
            out_kind_reg  <= a_kind_reg;
            out_log_reg   <= a_log_reg;
            out_value_reg <= a_direct_reg ? a_value_reg : conv_value;
        end
    end

    assign readings.valid         = out_valid_reg;
    assign readings.reading_kind  = out_kind_reg;
    assign readings.reading_value = out_value_reg;
    assign readings.log_ready     = out_log_reg;

    // temperature readings never flag a log
    `NDTP_ASSERT_IMP(a_temp_no_log, out_valid_reg && (out_kind_reg == ndtp_pkg::READ_TEMP), !out_log_reg)
    // a word in stage A is kept while the output is blocked
    `NDTP_ASSERT_NEXT(a_stage_holds, a_valid_reg && !out_ready, a_valid_reg)
    // the reciprocal product gives an exact quotient
    `NDTP_ASSERT_IMP(a_rem_range, a_valid_reg && !a_direct_reg, rem < 4'd9)

endmodule

// ----- hdl/nmea_depth_temp_parser_core.sv -----
// Top level of the NMEA depth/water-temperature sentence parser.
//
//   port      dir   word contents
//   --------  ----  ---------------------------------------------------
//   serial    in    rx_byte: one received NMEA character
//   readings  out   reading_kind, reading_value (thousandths), log_ready
//
// One character is taken per cycle while serial.ready is high. The CR/LF
// ending a valid $INDPT or $INMTW sentence reaches readings through the token
// register, the conversion stage (times-1/9 multiplier) and the output register.
// Reset clears the parser state asynchronously; there is no clearing pass.
// With readings stalled, up to three readings wait in the pipe; serial.ready
// falls only when the token register is full and cannot move on.
`timescale 1ns / 1ps

module nmea_depth_temp_parser_core #(
    parameter int MAX_BODY        = ndtp_pkg::MAX_BODY_DEF,
    parameter int FRACTION_DIGITS = ndtp_pkg::FRAC_DIGITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    ndtp_byte_if.sink      serial,
    ndtp_reading_if.source readings
);

    logic             tok_valid;
    logic             tok_ready;
    ndtp_pkg::token_t tok;

    // character parser and sentence token
    ndtp_parser #(
        .MAX_BODY        (MAX_BODY),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .serial    (serial),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

    // value conversion and output register
    ndtp_convert u_convert (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok),
        .readings  (readings)
    );

endmodule
